// ===== rtl/lmsb_pkg.sv =====
// Package for the LED matrix scan bit buffer.
// Holds command codes, state type, field widths and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmsb_pkg;

    localparam int ROWS_DEF    = 16;
    localparam int COLUMNS_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int BYTE_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ALL_OFF  = 3'd1,
        CMD_SET_COL  = 3'd2,
        CMD_SET_ROW  = 3'd3,
        CMD_TRANSMIT = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/led_matrix_scan_bit_buffer.sv =====
// Top level of the LED matrix scan bit buffer: command FSM, row-word RAM and byte sender.
// Depends on lmsb_pkg and lmsb_ram.
//
//   Channel   Direction  Handshake                Beat contents
//   command   in         start high, busy low     i_command, i_row, i_column, i_on
//   result    out        o_strobe, one cycle      o_data_byte, o_last_byte, o_row_was_set
//
// Every command first reads the row word from the RAM, then executes.
// A transmit then sends one byte per cycle, BPR bytes per row.
// Clear and all-off act through per-row valid bits; an invalid row reads all ones.
// Reset leaves every row invalid and every flag clear; there is no clearing pass.
// Results cannot be stalled; busy stays high until the last byte has been shown.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_scan_bit_buffer #(
    parameter int ROWS    = lmsb_pkg::ROWS_DEF,
    parameter int COLUMNS = lmsb_pkg::COLUMNS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lmsb_pkg::CMD_W-1:0]    i_command,
    input  wire logic [lmsb_pkg::ROW_W-1:0]    i_row,
    input  wire logic [lmsb_pkg::COL_W-1:0]    i_column,
    input  wire logic                          i_on,
    output logic                               o_strobe,
    output logic      [lmsb_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                               o_last_byte,
    output logic                               o_row_was_set
);

    localparam int BPR = 1 + (ROWS + COLUMNS - 1) / 8;
    localparam int WW  = BPR * lmsb_pkg::BYTE_W;
    localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW  = (AW > lmsb_pkg::ROW_W) ? AW : lmsb_pkg::ROW_W;
    localparam int CW  = (BPR > 1) ? $clog2(BPR) : 1;

    lmsb_pkg::t_state r_state, n_state;

    logic [lmsb_pkg::CMD_W-1:0] r_cmd;
    logic [AW-1:0]              r_row;
    logic [lmsb_pkg::COL_W-1:0] r_col;
    logic                       r_on;
    logic                       r_row_ok;
    logic                       r_col_ok;
    logic [ROWS-1:0]            r_valid;
    logic [ROWS-1:0]            r_flags;
    logic [WW-1:0]              r_word;
    logic                       r_flag;
    logic [CW-1:0]              r_cnt;

    logic [XW-1:0] w_row_x;
    logic          w_accept;
    logic [WW-1:0] w_rdata;
    logic [WW-1:0] w_word;
    logic [WW-1:0] w_wdata;
    logic          w_we;
    logic          w_last;

    assign w_row_x  = XW'(i_row);
    assign w_accept = start && (r_state == lmsb_pkg::ST_IDLE);
    assign w_last   = (r_cnt == CW'(BPR - 1));

    lmsb_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_row_x[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // A row that has not been written since clear or all-off reads as all ones.
    assign w_word = r_valid[r_row] ? w_rdata : '1;

    // Word bit index WW-1-p holds word position p, which keeps byte 0 on top, MSB first.
    always_comb begin
        w_wdata = w_word;
        w_we    = 1'b0;
        if (r_state == lmsb_pkg::ST_EXEC) begin
            case (r_cmd)
                lmsb_pkg::CMD_SET_COL: begin
                    w_we = r_row_ok && r_col_ok;
                    for (int k = 0; k < COLUMNS; k++) begin
                        if (32'(r_col) == k) begin
                            w_wdata[WW-1-k] = !r_on;
                        end
                    end
                end
                lmsb_pkg::CMD_SET_ROW: begin
                    w_we = r_row_ok;
                    for (int i = 0; i < ROWS; i++) begin
                        w_wdata[WW-1-COLUMNS-i] = !(r_on && (r_row == AW'(ROWS - 1 - i)));
                    end
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lmsb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lmsb_pkg::ST_EXEC;
                end
            end
            lmsb_pkg::ST_EXEC: begin
                if (r_cmd == lmsb_pkg::CMD_TRANSMIT && r_row_ok) begin
                    n_state = lmsb_pkg::ST_SEND;
                end else begin
                    n_state = lmsb_pkg::ST_IDLE;
                end
            end
            lmsb_pkg::ST_SEND: begin
                if (w_last) begin
                    n_state = lmsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy          = (r_state != lmsb_pkg::ST_IDLE);
        o_strobe      = (r_state == lmsb_pkg::ST_SEND);
        o_data_byte   = r_word[WW-1 -: lmsb_pkg::BYTE_W];
        o_last_byte   = w_last;
        o_row_was_set = r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmsb_pkg::ST_IDLE;
            r_valid <= '0;
            r_flags <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lmsb_pkg::ST_EXEC) begin
                case (r_cmd)
                    lmsb_pkg::CMD_CLEAR: begin
                        r_valid <= '0;
                        r_flags <= '0;
                    end
                    lmsb_pkg::CMD_ALL_OFF: begin
                        r_valid <= '0;
                        r_flags <= '1;
                    end
                    lmsb_pkg::CMD_SET_COL: begin
                        if (w_we) begin
                            r_valid[r_row] <= 1'b1;
                        end
                    end
                    lmsb_pkg::CMD_SET_ROW: begin
                        if (r_row_ok) begin
                            r_valid[r_row] <= 1'b1;
                            r_flags[r_row] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                r_cnt <= '0;
            end else if (r_state == lmsb_pkg::ST_SEND) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_command;
            r_row    <= w_row_x[AW-1:0];
            r_col    <= i_column;
            r_on     <= i_on;
            r_row_ok <= (32'(i_row) < ROWS);
            r_col_ok <= (32'(i_column) < COLUMNS);
        end
        if (r_state == lmsb_pkg::ST_EXEC) begin
            r_word <= w_word;
            r_flag <= r_flags[r_row];
        end else if (r_state == lmsb_pkg::ST_SEND) begin
            r_word <= r_word << lmsb_pkg::BYTE_W;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_byte) |=> !busy)
        else $error("block still busy after the last byte of a row");

    a_flag_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=> (o_strobe && $stable(o_row_was_set)))
        else $error("row transfer broke off or its flag changed");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == lmsb_pkg::ST_EXEC))
        else $error("RAM written outside the execute cycle");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmsb_pkg::ST_EXEC && r_cmd == lmsb_pkg::CMD_CLEAR)
            |=> (r_valid == '0 && r_flags == '0))
        else $error("clear left a row valid or a flag set");

endmodule

`default_nettype wire

// ===== rtl/lmsb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lmsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for led_matrix_scan_bit_buffer: directed and random command beats,
// with a row-word model that predicts and checks every transmitted byte in order.
// Depends on lmsb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
    import lmsb_pkg::*;

    localparam int ROWS        = ROWS_DEF;
    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int BPR         = 1 + (ROWS + COLUMNS - 1) / 8;
    localparam int RANDOM_CMDS = 336;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 12;

    localparam logic [CMD_W-1:0] CMD_RESERVED_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED_C = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             on;
    } t_scan_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              row_was_set;
    } t_scan_byte;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [CMD_W-1:0]    i_command = '0;
    logic [ROW_W-1:0]    i_row = '0;
    logic [COL_W-1:0]    i_column = '0;
    logic                i_on = 1'b0;
    logic                busy;
    logic                o_strobe;
    logic [BYTE_W-1:0]   o_data_byte;
    logic                o_last_byte;
    logic                o_row_was_set;

    t_scan_cmd  pending_cmds[$];
    t_scan_byte expected_bytes[$];
    logic [BYTE_W-1:0] row_bytes[ROWS][BPR];
    logic              row_flags[ROWS];

    int total_cmds;
    int cmds_accepted;
    int bytes_checked;
    int errors;
    int cycle_count;
    int gap_left;
    int burst_left;
    int roll;

    led_matrix_scan_bit_buffer #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_on          (i_on),
        .o_strobe      (o_strobe),
        .o_data_byte   (o_data_byte),
        .o_last_byte   (o_last_byte),
        .o_row_was_set (o_row_was_set)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void write_bit(int r, int pos, logic level);
        if (pos / 8 < BPR) begin
            row_bytes[r][pos / 8][7 - pos % 8] = level;
        end
    endfunction

    function automatic void drive_row_control(int r, logic drive_on);
        for (int i = 0; i < ROWS; i++) begin
            write_bit(r, COLUMNS + i, !(drive_on && i == ROWS - 1 - r));
        end
        row_flags[r] = 1'b1;
    endfunction

    function automatic void switch_all_off();
        for (int r = 0; r < ROWS; r++) begin
            for (int b = 0; b < BPR; b++) begin
                row_bytes[r][b] = 8'hFF;
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            drive_row_control(r, 1'b0);
        end
    endfunction

    function automatic void reset_scan_model();
        switch_all_off();
        for (int r = 0; r < ROWS; r++) begin
            row_flags[r] = 1'b0;
        end
    endfunction

    function automatic void apply_scan_command(t_scan_cmd c);
        t_scan_byte sb;
        int r;
        int col;
        r = int'(c.row);
        col = int'(c.column);
        case (c.command)
            CMD_CLEAR: begin
                reset_scan_model();
            end
            CMD_ALL_OFF: begin
                switch_all_off();
            end
            CMD_SET_COL: begin
                if (r < ROWS && col < COLUMNS) begin
                    write_bit(r, col, !c.on);
                end
            end
            CMD_SET_ROW: begin
                if (r < ROWS) begin
                    drive_row_control(r, c.on);
                end
            end
            CMD_TRANSMIT: begin
                if (r < ROWS) begin
                    for (int b = 0; b < BPR; b++) begin
                        sb.data_byte   = row_bytes[r][b];
                        sb.last_byte   = (b == BPR - 1);
                        sb.row_was_set = row_flags[r];
                        expected_bytes.push_back(sb);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, int r, int col, logic drive_on);
        t_scan_cmd c;
        c.command = cmd;
        c.row     = ROW_W'(r);
        c.column  = COL_W'(col);
        c.on      = drive_on;
        pending_cmds.push_back(c);
    endfunction

    // Driver: holds a beat until it is taken, then waits a random gap before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_scan_command('{i_command, i_row, i_column, i_on});
                cmds_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    t_scan_cmd c;
                    c = pending_cmds.pop_front();
                    start     <= 1'b1;
                    i_command <= c.command;
                    i_row     <= c.row;
                    i_column  <= c.column;
                    i_on      <= c.on;
                    roll = $urandom_range(0, 99);
                    if (burst_left > 0) begin
                        burst_left--;
                        gap_left = 0;
                    end else if (roll < 5) begin
                        burst_left = $urandom_range(10, 40);
                        gap_left = 0;
                    end else if (roll < 55) begin
                        gap_left = 0;
                    end else if (roll < 85) begin
                        gap_left = $urandom_range(1, 3);
                    end else if (roll < 97) begin
                        gap_left = $urandom_range(4, 12);
                    end else begin
                        gap_left = $urandom_range(20, 60);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed byte must match the oldest expected byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result beat: data_byte %0h", o_data_byte);
                errors++;
            end else begin
                t_scan_byte sb;
                sb = expected_bytes.pop_front();
                bytes_checked++;
                if (o_data_byte !== sb.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", sb.data_byte, o_data_byte);
                    errors++;
                end
                if (o_last_byte !== sb.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", sb.last_byte, o_last_byte);
                    errors++;
                end
                if (o_row_was_set !== sb.row_was_set) begin
                    $error("row_was_set: expected %0b, got %0b", sb.row_was_set,
                           o_row_was_set);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("led_matrix_scan_bit_buffer verification failed");
            $finish;
        end
    end

    initial begin
        int counted;
        int r;
        int k;
        int pick;
        reset_scan_model();

        add_cmd(CMD_TRANSMIT, 0, 0, 1'b0);
        add_cmd(CMD_TRANSMIT, ROWS - 1, COLUMNS - 1, 1'b1);
        add_cmd(CMD_SET_COL, 0, 0, 1'b1);
        add_cmd(CMD_SET_COL, 0, COLUMNS - 1, 1'b1);
        add_cmd(CMD_SET_ROW, 0, 0, 1'b1);
        add_cmd(CMD_TRANSMIT, 0, 0, 1'b0);
        add_cmd(CMD_SET_ROW, ROWS - 1, 0, 1'b1);
        add_cmd(CMD_SET_COL, ROWS - 1, 7, 1'b1);
        add_cmd(CMD_TRANSMIT, ROWS - 1, 0, 1'b0);
        add_cmd(CMD_SET_COL, 0, 0, 1'b0);
        add_cmd(CMD_SET_ROW, 0, COLUMNS - 1, 1'b0);
        add_cmd(CMD_TRANSMIT, 0, 0, 1'b1);
        add_cmd(CMD_RESERVED_A, ROWS - 1, COLUMNS - 1, 1'b1);
        add_cmd(CMD_RESERVED_B, 0, 0, 1'b0);
        add_cmd(CMD_RESERVED_C, 5, 10, 1'b1);
        add_cmd(CMD_ALL_OFF, 3, 3, 1'b1);
        add_cmd(CMD_TRANSMIT, 0, 0, 1'b0);
        add_cmd(CMD_TRANSMIT, 7, 0, 1'b0);
        add_cmd(CMD_SET_COL, 7, 8, 1'b1);
        add_cmd(CMD_CLEAR, 9, 9, 1'b0);
        add_cmd(CMD_TRANSMIT, 7, 0, 1'b0);
        add_cmd(CMD_TRANSMIT, ROWS - 1, 0, 1'b0);

        // Random part: mostly row refresh sequences, the rest single commands as noise.
        counted = 0;
        while (counted < RANDOM_CMDS) begin
            if ($urandom_range(0, 99) < 60) begin
                r = $urandom_range(0, 15);
                k = $urandom_range(1, 6);
                repeat (k) begin
                    add_cmd(CMD_SET_COL, r, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
                end
                add_cmd(CMD_SET_ROW, r, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
                add_cmd(CMD_TRANSMIT, r, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
                counted += k + 2;
            end else begin
                pick = $urandom_range(0, 99);
                r = $urandom_range(0, 15);
                k = $urandom_range(0, 15);
                counted++;
                if (pick < 30) begin
                    add_cmd(CMD_TRANSMIT, r, k, 1'($urandom_range(0, 1)));
                end else if (pick < 60) begin
                    add_cmd(CMD_SET_COL, r, k, 1'($urandom_range(0, 1)));
                end else if (pick < 78) begin
                    add_cmd(CMD_SET_ROW, r, k, 1'($urandom_range(0, 1)));
                end else if (pick < 84) begin
                    add_cmd(CMD_CLEAR, r, k, 1'($urandom_range(0, 1)));
                end else if (pick < 90) begin
                    add_cmd(CMD_ALL_OFF, r, k, 1'($urandom_range(0, 1)));
                end else begin
                    add_cmd(CMD_RESERVED_A + CMD_W'($urandom_range(0, 2)), r, k,
                            1'($urandom_range(0, 1)));
                    counted--;
                end
            end
        end
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < total_cmds || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        $display("Summary: %0d command beats driven, %0d transmitted bytes checked, %0d errors.",
                 cmds_accepted, bytes_checked, errors);
        if (errors == 0) begin
            $display("led_matrix_scan_bit_buffer verification clean");
        end else begin
            $display("led_matrix_scan_bit_buffer verification failed");
        end
        $finish;
    end

endmodule
